### src/aes_pkg.sv
package aes_pkg;

  localparam int unsigned Rounds = 10;
  localparam int unsigned KeyRegCount = 2;
  localparam logic [7:0] GfReduce = 8'h1b;
  localparam logic [7:0] GfTopbit = 8'h80;

  typedef enum logic [0:0] {
    REG_KEY_HIGH = 1'b0,
    REG_KEY_LOW = 1'b1
  } cfg_index_t;

  typedef logic [127:0] block_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] v);
    logic [7:0] t;
    t = {v[6:0], 1'b0};
    if ((v & GfTopbit) != 8'h00) begin
      t = t ^ GfReduce;
    end
    return t;
  endfunction

  // Byte i of a block sits in bits 127-8i downto 120-8i.
  function automatic logic [7:0] get_byte(input block_t b, input int unsigned i);
    return b[127 - 8 * i -: 8];
  endfunction

  function automatic block_t sub_shift(input block_t s);
    block_t o;
    o = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        o[127 - 8 * (r + 4 * c) -: 8] = SBOX[get_byte(s, r + 4 * ((c + r) % 4))];
      end
    end
    return o;
  endfunction

  function automatic block_t mix_columns(input block_t s);
    block_t o;
    logic [7:0] a, b, d2, d3, all;
    o = '0;
    for (int c = 0; c < 16; c += 4) begin
      a = get_byte(s, c);
      b = get_byte(s, c + 1);
      d2 = get_byte(s, c + 2);
      d3 = get_byte(s, c + 3);
      all = a ^ b ^ d2 ^ d3;
      o[127 - 8 * c -: 8] = a ^ all ^ xtime(a ^ b);
      o[127 - 8 * (c + 1) -: 8] = b ^ all ^ xtime(b ^ d2);
      o[127 - 8 * (c + 2) -: 8] = d2 ^ all ^ xtime(d2 ^ d3);
      o[127 - 8 * (c + 3) -: 8] = d3 ^ all ^ xtime(d3 ^ a);
    end
    return o;
  endfunction

  function automatic block_t next_round_key(input block_t k, input logic [7:0] rc);
    block_t o;
    logic [31:0] t;
    logic [31:0] w;
    t = {SBOX[k[23:16]] ^ rc, SBOX[k[15:8]], SBOX[k[7:0]], SBOX[k[31:24]]};
    w = k[127:96] ^ t;
    o[127:96] = w;
    w = k[95:64] ^ w;
    o[95:64] = w;
    w = k[63:32] ^ w;
    o[63:32] = w;
    o[31:0] = k[31:0] ^ w;
    return o;
  endfunction

endpackage

### src/aes_stream_if.sv
interface aes_stream_if;
  logic valid;
  logic ready;
  logic [63:0] data_high;
  logic [63:0] data_low;
  modport source (output valid, output data_high, output data_low, input ready);
  modport sink (input valid, input data_high, input data_low, output ready);
endinterface

### src/aes_cfg_if.sv
interface aes_cfg_if;
  logic valid;
  logic ready;
  logic index;
  logic [63:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

### src/aes128_block_encrypt.sv
// AES-128 encryptor with one pipeline stage per round.
// The key is written through cfg: index 0 loads key bytes 0 to 7, index 1 loads
// key bytes 8 to 15. Both registers reset to zero. Writes are taken at any time,
// and a new key applies to blocks accepted after the write.
// Plaintext enters on plain as two 64-bit halves and ciphertext leaves on
// cipher in the same layout, byte 0 in the top bits of the high half.
// Each stage carries its state, its round key and a valid bit, so the round
// keys are expanded alongside the data and every block keeps its own key.
// From accepted input to result valid, a block passes through the input register
// and ten round stages, the last of which is the output register. One block is
// accepted every cycle while the output is taken. When the receiver stalls, the
// whole pipeline holds, except that empty stages still fill, so no block is
// lost or repeated.
// Reset clears all valid bits and the key registers.
module aes128_block_encrypt
  import aes_pkg::*;
(
  input logic clk,
  input logic rst,
  aes_cfg_if.sink cfg,
  aes_stream_if.sink plain,
  aes_stream_if.source cipher
);

  logic [63:0] key_high;
  logic [63:0] key_low;

  // Stage 0 is the input register; stage Rounds is the output register.
  logic valid [Rounds + 1];
  block_t state [Rounds + 1];
  block_t rkey [Rounds + 1];
  logic [7:0] rcon [Rounds + 1];
  logic advance [Rounds + 1];

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= '0;
      key_low <= '0;
    end else if (cfg.valid) begin
      unique case (cfg_index_t'(cfg.index))
        REG_KEY_HIGH: key_high <= cfg.data;
        REG_KEY_LOW: key_low <= cfg.data;
        default: ;
      endcase
    end
  end

  assign advance[Rounds] = !valid[Rounds] || cipher.ready;
  for (genvar i = Rounds - 1; i >= 0; i--) begin : g_adv
    assign advance[i] = !valid[i] || advance[i + 1];
  end

  assign plain.ready = advance[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid[0] <= 1'b0;
    end else if (advance[0]) begin
      valid[0] <= plain.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance[0]) begin
      state[0] <= {plain.data_high, plain.data_low};
      rkey[0] <= {key_high, key_low};
      rcon[0] <= 8'h01;
    end
  end

  for (genvar r = 1; r <= Rounds; r++) begin : g_round
    block_t mixed;
    block_t subbed;
    assign subbed = sub_shift(state[r - 1] ^ rkey[r - 1]);
    if (r < Rounds) begin : g_mix
      assign mixed = mix_columns(subbed);
    end else begin : g_last
      assign mixed = subbed;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        valid[r] <= 1'b0;
      end else if (advance[r]) begin
        valid[r] <= valid[r - 1];
      end
    end

    always_ff @(posedge clk) begin
      if (advance[r]) begin
        rkey[r] <= next_round_key(rkey[r - 1], rcon[r - 1]);
        rcon[r] <= xtime(rcon[r - 1]);
        if (r == Rounds) begin
          state[r] <= mixed ^ next_round_key(rkey[r - 1], rcon[r - 1]);
        end else begin
          state[r] <= mixed;
        end
      end
    end
  end

  assign cipher.valid = valid[Rounds];
  assign cipher.data_high = state[Rounds][127:64];
  assign cipher.data_low = state[Rounds][63:0];

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    cipher.valid && !cipher.ready |=> cipher.valid && $stable(state[Rounds]))
    else $error("result changed while stalled");

  a_last_stage_fill: assert property (@(posedge clk) disable iff (rst)
    valid[Rounds - 1] && advance[Rounds] |=> cipher.valid)
    else $error("block lost at output stage");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !valid[0] |-> plain.ready)
    else $error("input stalled with empty entry stage");

endmodule
